// ----- rtl/core/f88dt_pkg.sv -----
`timescale 1ns / 1ps

package f88dt_pkg;

  localparam int unsigned RawWidth  = 16;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned FracWidth = 8;
  localparam int unsigned IntWidth  = 8;
  localparam int unsigned DigWidth  = 4;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharDot   = 8'h2E;
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_HUND,
    ST_TENS,
    ST_ONES,
    ST_DOT,
    ST_FRAC
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } frac_ctl_t;

  typedef struct packed {
    logic [DigWidth-1:0] hund;
    logic [DigWidth-1:0] tens;
    logic [DigWidth-1:0] ones;
    logic                show_hund;
    logic                show_tens;
  } int_digits_t;

  // Splits an integer part of 0..128 into decimal digits. The tens digit uses
  // the reciprocal 205/2048, which is exact for values below 1029.
  function automatic int_digits_t split_int(input logic [IntWidth-1:0] ip);
    int_digits_t         d;
    logic [IntWidth-1:0] rem;
    logic [15:0]         prod;
    logic [IntWidth-1:0] tens_x10;
    d.show_hund = (ip >= IntWidth'(100));
    d.show_tens = (ip >= IntWidth'(10));
    rem         = d.show_hund ? (ip - IntWidth'(100)) : ip;
    d.hund      = d.show_hund ? DigWidth'(1) : DigWidth'(0);
    prod        = 16'(rem) * 16'd205;
    d.tens      = prod[14:11];
    tens_x10    = {1'b0, d.tens, 3'b000} + {3'b000, d.tens, 1'b0};
    tens_x10    = IntWidth'(tens_x10);
    d.ones      = DigWidth'(rem - tens_x10);
    return d;
  endfunction

endpackage

// ----- rtl/core/f88dt_frac_unit.sv -----
`timescale 1ns / 1ps

module f88dt_frac_unit (
  input  logic                              clk,
  input  f88dt_pkg::frac_ctl_t              ctl,
  input  logic [f88dt_pkg::FracWidth-1:0]   load_frac,
  output logic [f88dt_pkg::DigWidth-1:0]    digit,
  output logic                              frac_zero,
  output logic                              rest_zero
);

  logic [f88dt_pkg::FracWidth-1:0]                      frac_r;
  logic [f88dt_pkg::FracWidth-1:0]                      frac_nxt;
  logic [f88dt_pkg::FracWidth+f88dt_pkg::DigWidth-1:0]  prod;

  // Ten times the fraction as a shift-add; the top nibble is the next digit.
  assign prod = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0};

  assign digit     = prod[f88dt_pkg::FracWidth+:f88dt_pkg::DigWidth];
  assign rest_zero = (prod[f88dt_pkg::FracWidth-1:0] == '0);
  assign frac_zero = (frac_r == '0);

  always_comb begin
    frac_nxt = frac_r;
    if (ctl.load) begin
      frac_nxt = load_frac;
    end else if (ctl.step) begin
      frac_nxt = prod[f88dt_pkg::FracWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
  end

endmodule

// ----- rtl/core/fixed_8_8_to_decimal_text_unit.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                 Handshake
// request   in_raw_value                          start high while busy low
// result    out_character, out_last               out_strobe, one cycle each
//
// A request keeps busy high until its last character is produced; one value
// gives at most 13 characters, one per cycle.
// The fraction digits come from one shared multiply-by-ten shift-add unit,
// one digit per cycle.
// Reset is synchronous on rst_n low and returns the sequencer to idle.
// The receiver cannot stall; a new request may start while the last
// character of the previous one is on the result ports.

module fixed_8_8_to_decimal_text_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [f88dt_pkg::RawWidth-1:0]      in_raw_value,
  output logic                                out_strobe,
  output logic [f88dt_pkg::CharWidth-1:0]     out_character,
  output logic                                out_last
);

  f88dt_pkg::state_t                   state_r;
  f88dt_pkg::state_t                   state_nxt;
  f88dt_pkg::state_t                   first_int;
  f88dt_pkg::int_digits_t              dig_r;
  f88dt_pkg::int_digits_t              dig_nxt;
  f88dt_pkg::frac_ctl_t                frac_ctl;
  logic                                accept;
  logic [f88dt_pkg::RawWidth-1:0]      mag;
  logic [f88dt_pkg::DigWidth-1:0]      frac_digit;
  logic                                frac_zero;
  logic                                rest_zero;
  logic                                emit;
  logic [f88dt_pkg::CharWidth-1:0]     emit_char;
  logic                                emit_last;
  logic                                out_strobe_r;
  logic [f88dt_pkg::CharWidth-1:0]     out_character_r;
  logic                                out_last_r;

  assign accept = start && !busy;
  assign busy   = (state_r != f88dt_pkg::ST_IDLE);
  assign mag    = in_raw_value[f88dt_pkg::RawWidth-1]
                ? (~in_raw_value + f88dt_pkg::RawWidth'(1)) : in_raw_value;

  assign dig_nxt = accept ? f88dt_pkg::split_int(mag[f88dt_pkg::RawWidth-1:f88dt_pkg::FracWidth])
                          : dig_r;

  always_comb begin
    if (dig_r.show_hund) begin
      first_int = f88dt_pkg::ST_HUND;
    end else if (dig_r.show_tens) begin
      first_int = f88dt_pkg::ST_TENS;
    end else begin
      first_int = f88dt_pkg::ST_ONES;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      f88dt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_raw_value[f88dt_pkg::RawWidth-1]) begin
            state_nxt = f88dt_pkg::ST_SIGN;
          end else if (dig_nxt.show_hund) begin
            state_nxt = f88dt_pkg::ST_HUND;
          end else if (dig_nxt.show_tens) begin
            state_nxt = f88dt_pkg::ST_TENS;
          end else begin
            state_nxt = f88dt_pkg::ST_ONES;
          end
        end
      end
      f88dt_pkg::ST_SIGN: state_nxt = first_int;
      f88dt_pkg::ST_HUND: state_nxt = f88dt_pkg::ST_TENS;
      f88dt_pkg::ST_TENS: state_nxt = f88dt_pkg::ST_ONES;
      f88dt_pkg::ST_ONES: state_nxt = frac_zero ? f88dt_pkg::ST_IDLE : f88dt_pkg::ST_DOT;
      f88dt_pkg::ST_DOT:  state_nxt = f88dt_pkg::ST_FRAC;
      f88dt_pkg::ST_FRAC: state_nxt = rest_zero ? f88dt_pkg::ST_IDLE : f88dt_pkg::ST_FRAC;
      default:            state_nxt = f88dt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    emit          = 1'b1;
    emit_char     = f88dt_pkg::CharZero;
    emit_last     = 1'b0;
    frac_ctl.load = accept;
    frac_ctl.step = 1'b0;
    case (state_r)
      f88dt_pkg::ST_IDLE: begin
        emit = 1'b0;
      end
      f88dt_pkg::ST_SIGN: begin
        emit_char = f88dt_pkg::CharMinus;
      end
      f88dt_pkg::ST_HUND: begin
        emit_char = f88dt_pkg::CharZero + f88dt_pkg::CharWidth'(dig_r.hund);
      end
      f88dt_pkg::ST_TENS: begin
        emit_char = f88dt_pkg::CharZero + f88dt_pkg::CharWidth'(dig_r.tens);
      end
      f88dt_pkg::ST_ONES: begin
        emit_char = f88dt_pkg::CharZero + f88dt_pkg::CharWidth'(dig_r.ones);
        emit_last = frac_zero;
      end
      f88dt_pkg::ST_DOT: begin
        emit_char = f88dt_pkg::CharDot;
      end
      f88dt_pkg::ST_FRAC: begin
        emit_char     = f88dt_pkg::CharZero + f88dt_pkg::CharWidth'(frac_digit);
        emit_last     = rest_zero;
        frac_ctl.step = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  f88dt_frac_unit u_frac (
    .clk       (clk),
    .ctl       (frac_ctl),
    .load_frac (mag[f88dt_pkg::FracWidth-1:0]),
    .digit     (frac_digit),
    .frac_zero (frac_zero),
    .rest_zero (rest_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= f88dt_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    dig_r           <= dig_nxt;
    out_character_r <= emit_char;
    out_last_r      <= emit_last;
  end

  assign out_strobe    = out_strobe_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request taken but sequencer did not start");

  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> $past(busy))
    else $error("character emitted without an active request");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("sequencer still busy after the final character");

  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy) && $past(rst_n)) |-> !$past(out_strobe) || $past(out_last))
    else $error("new request started before the previous text ended");

endmodule
